// ----- rtl/core/rms_pkg.sv -----
// ----------------------------------------------------------------------------
// rms_pkg
// Shared widths, defaults and arithmetic helpers of the running median block.
// ----------------------------------------------------------------------------
`default_nettype none

package rms_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned SumW        = 64;
  localparam int unsigned CapacityDef = 1024;

  // Mean of two middle samples: 33-bit sum halved, truncated toward zero.
  function automatic logic signed [DataW-1:0] pair_half(
    input logic signed [DataW-1:0] a,
    input logic signed [DataW-1:0] b
  );
    logic signed [DataW:0] s;
    logic signed [DataW:0] r;
    begin
      s = {a[DataW-1], a} + {b[DataW-1], b};
      r = (s + {{DataW{1'b0}}, s[DataW]}) >>> 1;
      pair_half = r[DataW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rms_ram.sv -----
// ----------------------------------------------------------------------------
// rms_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/running_median_sum.sv -----
// Flow: an accepted word walks down the store, one RAM read per compare with
// each entry larger than it; then the two middle entries are read and the
// result is sent. An empty or full store skips the walk. A new word is taken
// only after the last result is registered; a stalled result holds it back.
// Reset: asynchronous active-low reset empties the store and clears the sum;
// the RAM contents are not cleared, entries beyond the count are never read.
// ----------------------------------------------------------------------------
// running_median_sum
// Sorted-store running median with a wrapping 64-bit sum of the medians.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_sum
  import rms_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [DataW-1:0] value_i,
  input  wire logic                    new_set_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [DataW-1:0]      median_o,
  output logic signed [SumW-1:0]       total_o,
  output logic                         full_res_o
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  // The store is kept sorted ascending in one RAM. An insert walks down from
  // the top: each step reads the entry below the hole, and if it is larger
  // than the new word it moves up one place. Then the two middle entries are
  // read back and combined into the median.
  typedef enum logic [2:0] {
    StIdle,
    StInsRd,
    StInsCmp,
    StInsWr,
    StMedLo,
    StMedHi,
    StMedOut
  } state_e;

  state_e                  state_q;
  logic signed [DataW-1:0] val_q;
  logic [AddrW-1:0]        pos_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [SumW-1:0]  sum_q;
  logic                    full_q;
  logic signed [DataW-1:0] lo_q;

  logic                    ram_we;
  logic [AddrW-1:0]        ram_waddr;
  logic [DataW-1:0]        ram_wdata;
  logic                    ram_re;
  logic [AddrW-1:0]        ram_raddr;
  logic [DataW-1:0]        ram_rdata;
  logic signed [DataW-1:0] rd_s;

  logic [CntW-1:0]         cnt_eff;
  logic [CntW-1:0]         lo_idx;
  logic [CntW-1:0]         hi_idx;
  logic signed [DataW-1:0] med;
  logic                    out_free;

  assign rd_s     = ram_rdata;
  assign cnt_eff  = new_set_i ? '0 : cnt_q;
  assign lo_idx   = (cnt_q - CntW'(1)) >> 1;
  assign hi_idx   = cnt_q >> 1;
  assign med      = cnt_q[0] ? lo_q : pair_half(lo_q, rd_s);
  assign out_free = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = val_q;
    ram_re    = 1'b0;
    ram_raddr = pos_q - AddrW'(1);
    unique case (state_q)
      StIdle: begin
        // An insert into an empty store goes straight to entry zero.
        if (in_valid_i && cnt_eff == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = value_i;
        end
      end
      StInsRd: begin
        ram_re = 1'b1;
      end
      StInsCmp: begin
        ram_we    = 1'b1;
        ram_wdata = (rd_s > val_q) ? ram_rdata : val_q;
      end
      StInsWr: begin
        ram_we = 1'b1;
      end
      StMedLo: begin
        ram_re    = 1'b1;
        ram_raddr = lo_idx[AddrW-1:0];
      end
      StMedHi: begin
        ram_re    = 1'b1;
        ram_raddr = hi_idx[AddrW-1:0];
      end
      StMedOut: begin
      end
      default: begin
      end
    endcase
  end

  rms_ram #(
    .Width (DataW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      sum_q       <= '0;
      full_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            val_q <= value_i;
            pos_q <= cnt_eff[AddrW-1:0];
            if (new_set_i) begin
              sum_q <= '0;
            end
            if (cnt_eff == CapCnt) begin
              // Store full: the word is dropped, the median is still reported.
              full_q  <= 1'b1;
              state_q <= StMedLo;
            end else begin
              full_q  <= 1'b0;
              cnt_q   <= cnt_eff + CntW'(1);
              state_q <= (cnt_eff == '0) ? StMedLo : StInsRd;
            end
          end
        end
        StInsRd: begin
          state_q <= StInsCmp;
        end
        StInsCmp: begin
          if (rd_s > val_q) begin
            pos_q <= pos_q - AddrW'(1);
            state_q <= (pos_q == AddrW'(1)) ? StInsWr : StInsRd;
          end else begin
            state_q <= StMedLo;
          end
        end
        StInsWr: begin
          state_q <= StMedLo;
        end
        StMedLo: begin
          state_q <= StMedHi;
        end
        StMedHi: begin
          lo_q    <= rd_s;
          state_q <= StMedOut;
        end
        StMedOut: begin
          // The read data register holds while the result waits for room.
          if (out_free) begin
            median_o    <= med;
            full_res_o  <= full_q;
            out_valid_o <= 1'b1;
            if (full_q) begin
              total_o <= sum_q;
            end else begin
              sum_q   <= sum_q + SumW'(med);
              total_o <= sum_q + SumW'(med);
            end
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rms_checker.sv -----
// ----------------------------------------------------------------------------
// rms_checker
// Port-level checks of the running median block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_checker
  import rms_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire logic signed [DataW-1:0] value_i,
  input wire logic                    new_set_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic signed [DataW-1:0] median_o,
  input wire logic signed [SumW-1:0]  total_o,
  input wire logic                    full_res_o
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_q;
  logic [1:0] ns_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Words in flight and, per word, whether it opened a new set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      ns_q   <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (in_acc && out_acc) begin
        ns_q <= {1'b0, new_set_i};
      end else if (in_acc) begin
        ns_q <= (pend_q == 2'd0) ? {1'b0, new_set_i} : {new_set_i, ns_q[0]};
      end else if (out_acc) begin
        ns_q <= {1'b0, ns_q[1]};
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(median_o)
      && $stable(total_o) && $stable(full_res_o))
    else $error("result word changed while stalled");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two words in flight");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result word without an accepted input word");

  a_new_set_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && ns_q[0] |-> !full_res_o
      && total_o == {{(SumW-DataW){median_o[DataW-1]}}, median_o})
    else $error("first total of a new set is not its median");

endmodule

bind running_median_sum rms_checker u_rms_checker (.*);

`default_nettype wire
